### src/gdr_pkg.sv
// Package for the grid DDA ray caster: constants, queue item type and engine states.
// No dependencies; imported by gdr_front, gdr_back and the top level.
`default_nettype none
package gdr_pkg;
  localparam int MapCellsDef   = 4096;
  localparam int MapSideMaxDef = 64;
  localparam logic [7:0]  EmptyCell   = 8'd32;
  localparam logic [7:0]  TextureBase = 8'd48;
  localparam logic [21:0] StepSat     = 22'h3FFFFF;
  localparam int RootW = 26;
  localparam int LenW  = 22;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCast  = 1'b1;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMaxDist = 2'd2;

  typedef struct packed {
    logic        command;
    logic [11:0] cell_index;
    logic [7:0]  cell_value;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] direction_x;
    logic [15:0] direction_y;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SQRT, S_DIV, S_LEN, S_STEP, S_CHECK, S_HITMUL, S_HITSUM
  } state_t;
endpackage
`default_nettype wire

### src/gdr_front.sv
// Front end: takes input beats, unpacks them into items and holds them in a two-entry queue.
// Depends on gdr_pkg.
`default_nettype none
module gdr_front
  import gdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,
  input  wire logic        s_tuser,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);
  item_t      slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  item_t      in_item;
  logic       push, pop;

  assign in_item = '{command: s_tuser, cell_index: s_tdata[11:0], cell_value: s_tdata[19:12],
                     origin_x: s_tdata[35:20], origin_y: s_tdata[51:36],
                     direction_x: s_tdata[67:52], direction_y: s_tdata[83:68]};
  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### src/gdr_back.sv
// Back end: tile map memory, step-length setup (square root, divides) and the DDA walk.
// Depends on gdr_pkg; fed by gdr_front.
`default_nettype none
module gdr_back
  import gdr_pkg::*;
#(
  parameter int MAP_CELLS    = MapCellsDef,
  parameter int MAP_SIDE_MAX = MapSideMaxDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  input  wire logic [6:0]  map_width,
  input  wire logic [6:0]  map_height,
  input  wire logic [15:0] max_distance,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tuser
);
  localparam int AddrW = $clog2(MAP_CELLS);

  logic [7:0] map_mem [MAP_CELLS];
  logic [7:0] rdata;

  state_t state, state_next;

  item_t            cur;
  logic [15:0]      ax, ay;
  logic [51:0]      rad, res, sbit;
  logic [RootW-1:0] qr, qx, qy;
  logic [16:0]      remx, remy;
  logic [4:0]       cnt;
  logic [LenW-1:0]  ux, uy, lx, ly, ray_dist;
  logic signed [7:0] cx, cy;
  logic [7:0]       hit_cell;
  logic [31:0]      offx, offy;
  logic             neg_x, neg_y;
  logic [6:0]       w, h;

  // Combinational helpers
  logic [51:0]      sq_try;
  logic [16:0]      rx_s, ry_s;
  logic [32:0]      px, py;
  logic [22:0]      nlx, nly;
  logic             go_x;
  logic signed [7:0] ncx, ncy;
  logic [21:0]      ndist;
  logic [31:0]      addr;
  logic             out_of_map, too_far;
  logic [17:0]      hx_sum, hy_sum;
  logic [15:0]      hx, hy;
  logic             out_free;
  logic             accept_item;
  logic [31:0]      widx;

  assign neg_x = cur.direction_x[15];
  assign neg_y = cur.direction_y[15];
  assign w = (map_width == 7'd0) ? 7'd1 :
             (32'(map_width) > 32'(MAP_SIDE_MAX)) ? 7'(MAP_SIDE_MAX) : map_width;
  assign h = (map_height == 7'd0) ? 7'd1 :
             (32'(map_height) > 32'(MAP_SIDE_MAX)) ? 7'(MAP_SIDE_MAX) : map_height;

  assign out_free    = !m_tvalid || m_tready;
  assign accept_item = (state == S_IDLE) && q_valid && (q_item.command == CmdWrite || out_free);
  assign q_pop       = accept_item;
  assign widx        = 32'(q_item.cell_index);

  assign sq_try = res + sbit;
  assign rx_s   = {remx[15:0], qr[RootW-1]};
  assign ry_s   = {remy[15:0], qr[RootW-1]};
  assign px = 33'(neg_x ? {1'b0, cur.origin_x[9:0]} : 11'd1024 - {1'b0, cur.origin_x[9:0]})
              * 33'(ux);
  assign py = 33'(neg_y ? {1'b0, cur.origin_y[9:0]} : 11'd1024 - {1'b0, cur.origin_y[9:0]})
              * 33'(uy);

  assign go_x = lx < ly;
  assign ncx  = go_x ? (neg_x ? cx - 8'sd1 : cx + 8'sd1) : cx;
  assign ncy  = go_x ? cy : (neg_y ? cy - 8'sd1 : cy + 8'sd1);
  assign ndist = go_x ? lx : ly;
  assign nlx  = 23'(lx) + 23'(ux);
  assign nly  = 23'(ly) + 23'(uy);
  assign too_far = ndist > 22'(max_distance);
  assign addr = 32'(ncy[6:0]) * 32'(w) + 32'(ncx[6:0]);
  assign out_of_map = ncx < 8'sd0 || ncy < 8'sd0 || ncx >= $signed({1'b0, w}) ||
                      ncy >= $signed({1'b0, h}) || addr >= 32'(MAP_CELLS);

  // The offset reaches 17 bits, so the sum needs 18 before it saturates.
  assign hx_sum = 18'(cur.origin_x) + 18'(offx[31:14]);
  assign hy_sum = 18'(cur.origin_y) + 18'(offy[31:14]);
  assign hx = neg_x ? ((32'(offx[31:14]) > 32'(cur.origin_x)) ? 16'd0
                       : cur.origin_x - 16'(offx[31:14]))
                    : ((hx_sum[17:16] != 2'b00) ? 16'hFFFF : hx_sum[15:0]);
  assign hy = neg_y ? ((32'(offy[31:14]) > 32'(cur.origin_y)) ? 16'd0
                       : cur.origin_y - 16'(offy[31:14]))
                    : ((hy_sum[17:16] != 2'b00) ? 16'hFFFF : hy_sum[15:0]);

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept_item && q_item.command == CmdWrite && widx < 32'(MAP_CELLS))
      map_mem[widx[AddrW-1:0]] <= q_item.cell_value;
    rdata <= map_mem[addr[AddrW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept_item && q_item.command == CmdCast) state_next = S_SQUARE;
      S_SQUARE: state_next = S_SQRT;
      S_SQRT:   if (sbit == 52'd0) state_next = S_DIV;
      S_DIV:    if (cnt == 5'(RootW - 1)) state_next = S_LEN;
      S_LEN:    state_next = S_STEP;
      S_STEP:   state_next = (too_far || out_of_map) ? S_IDLE : S_CHECK;
      S_CHECK:  state_next = (rdata != EmptyCell) ? S_HITMUL : S_STEP;
      S_HITMUL: state_next = S_HITSUM;
      S_HITSUM: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept_item) begin
          cur <= q_item;
          ax <= q_item.direction_x[15] ? 16'(-q_item.direction_x) : q_item.direction_x;
          ay <= q_item.direction_y[15] ? 16'(-q_item.direction_y) : q_item.direction_y;
          cx <= $signed({2'b00, q_item.origin_x[15:10]});
          cy <= $signed({2'b00, q_item.origin_y[15:10]});
        end
      end
      S_SQUARE: begin
        rad  <= (52'(32'(ax) * 32'(ax)) + 52'(32'(ay) * 32'(ay))) << 20;
        res  <= 52'd0;
        sbit <= 52'd1 << 50;
      end
      S_SQRT: begin
        if (sbit != 52'd0) begin
          if (rad >= sq_try) begin
            rad <= rad - sq_try;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
        end else begin
          qr   <= res[RootW-1:0];
          remx <= 17'd0;
          remy <= 17'd0;
          cnt  <= 5'd0;
        end
      end
      S_DIV: begin
        qr  <= qr << 1;
        cnt <= cnt + 5'd1;
        if (rx_s >= 17'(ax)) begin
          remx <= rx_s - 17'(ax);
          qx <= {qx[RootW-2:0], 1'b1};
        end else begin
          remx <= rx_s;
          qx <= {qx[RootW-2:0], 1'b0};
        end
        if (ry_s >= 17'(ay)) begin
          remy <= ry_s - 17'(ay);
          qy <= {qy[RootW-2:0], 1'b1};
        end else begin
          remy <= ry_s;
          qy <= {qy[RootW-2:0], 1'b0};
        end
        // The last quotient bit joins the 25 already shifted in; any of the top four set
        // means the step length is past the saturation limit.
        if (cnt == 5'(RootW - 1)) begin
          if (ax == 16'd0) ux <= StepSat;
          else begin
            ux <= (qx[RootW-2:LenW-1] != '0) ? StepSat
                  : LenW'({qx[RootW-2:0], (rx_s >= 17'(ax))});
          end
          if (ay == 16'd0) uy <= StepSat;
          else begin
            uy <= (qy[RootW-2:LenW-1] != '0) ? StepSat
                  : LenW'({qy[RootW-2:0], (ry_s >= 17'(ay))});
          end
        end
      end
      S_LEN: begin
        lx <= (px[32:10] > 23'(StepSat)) ? StepSat : px[31:10];
        ly <= (py[32:10] > 23'(StepSat)) ? StepSat : py[31:10];
      end
      S_STEP: begin
        cx       <= ncx;
        cy       <= ncy;
        ray_dist <= ndist;
        if (go_x) lx <= (nlx > 23'(StepSat)) ? StepSat : nlx[LenW-1:0];
        else      ly <= (nly > 23'(StepSat)) ? StepSat : nly[LenW-1:0];
      end
      S_CHECK:  hit_cell <= rdata;
      S_HITMUL: begin
        offx <= 32'(ax) * 32'(ray_dist[15:0]);
        offy <= 32'(ay) * 32'(ray_dist[15:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_STEP && (too_far || out_of_map)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= 1'b0;
        m_tdata  <= 40'd0;
      end else if (state == S_HITSUM) begin
        m_tvalid <= 1'b1;
        m_tuser  <= 1'b1;
        m_tdata  <= {hit_cell - TextureBase, hy, hx};
      end
    end
  end
endmodule
`default_nettype wire

### src/grid_dda_ray_cast_top.sv
// Top level of the grid DDA ray caster: APB register file, front queue and back engine.
// Depends on gdr_pkg, gdr_front and gdr_back.
// A map write is taken by the engine while idle and gives no result beat. A cast runs through
// setup (squaring, a square root, divides, first lengths), then a step state and a check state
// per grid step, each step reading the map memory once, and two more states on a hit; the walk
// takes at most 127 steps on a 64x64 map.
// Throughput: one cast at a time; the two-entry input queue takes beats while the engine runs.
// Reset (rst, synchronous, active high) empties the queue, idles the engine and loads
// map_width=64, map_height=64, max_distance=61440. The map is not cleared.
`default_nettype none
module grid_dda_ray_cast_top
  import gdr_pkg::*;
#(
  parameter int MAP_CELLS    = MapCellsDef,
  parameter int MAP_SIDE_MAX = MapSideMaxDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input beats. tdata from bit 0: cell_index[11:0], cell_value[7:0], origin_x[15:0],
  // origin_y[15:0], direction_x[15:0], direction_y[15:0], zero pad to 88 bits.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,
  input  wire logic        s_tuser,   // command: 0 writes a map cell, 1 casts a ray
  // Result beats. tdata from bit 0: hit_x[15:0], hit_y[15:0], texture_id[7:0].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tuser,   // hit_found
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [6:0]  map_width, map_height;
  logic [15:0] max_distance;
  logic        q_valid, q_pop;
  item_t       q_item;

  assign pready = 1'b1;

  // Registers sit at byte addresses 0, 4 and 8.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= 7'd64;
      map_height   <= 7'd64;
      max_distance <= 16'd61440;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegWidth:   map_width    <= pwdata[6:0];
        RegHeight:  map_height   <= pwdata[6:0];
        RegMaxDist: max_distance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWidth:   prdata = 32'(map_width);
      RegHeight:  prdata = 32'(map_height);
      RegMaxDist: prdata = 32'(max_distance);
      default:    prdata = 32'd0;
    endcase
  end

  gdr_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_valid, .q_item, .q_pop
  );

  gdr_back #(.MAP_CELLS(MAP_CELLS), .MAP_SIDE_MAX(MAP_SIDE_MAX)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop,
    .map_width, .map_height, .max_distance,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );
endmodule
`default_nettype wire

### src/gdr_checker.sv
// Port-level checker for the ray caster, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module gdr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        pready
);
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 40'd0) else $error("miss beat carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat after reset");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind grid_dda_ray_cast_top gdr_checker u_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .pready
);
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_dda_ray_cast_top. It holds its own DDA ray caster and map copy.
// Depends on gdr_pkg and the block's RTL; stream beats are checked against predicted hits.
module tb;
  import gdr_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  tex;
  } hit_t;

  // Map shapes below never reach past this many cells, so only these are filled up front.
  localparam int FillCells = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_dda_ray_cast_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow of the block's map and registers, as the predictor sees them.
  logic [7:0]  map_copy [MapCellsDef];
  logic [6:0]  width_reg = 7'd64;
  logic [6:0]  height_reg = 7'd64;
  logic [15:0] range_reg = 16'd61440;

  item_t pending_beats [$];
  hit_t  expected_hits [$];
  int    errors = 0;
  int    casts_seen = 0;
  int    hits_seen = 0;
  int    writes_sent = 0;
  int    accept_count = 0;
  int    accept_seen = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_count = 0;
  bit    quiet = 1'b0;
  bit    send_hold = 1'b0;
  bit    hold_req = 1'b0;
  item_t cur_beat = '0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sat_len(longint v);
    return (v > longint'(StepSat)) ? longint'(StepSat) : v;
  endfunction

  function automatic int clamp_side(logic [6:0] v);
    if (v < 1) return 1;
    if (v > MapSideMaxDef) return MapSideMaxDef;
    return int'(v);
  endfunction

  function automatic logic [15:0] hit_coord(logic [15:0] org, int d, longint walk_len);
    longint mag = (d < 0) ? -d : d;
    longint off = (mag * walk_len) >>> 14;
    if (d < 0) return (off > org) ? 16'd0 : 16'(org - off);
    return (org + off > 65535) ? 16'hFFFF : 16'(org + off);
  endfunction

  // Walks the ray through the shadow map and returns the hit it should produce.
  function automatic hit_t trace_ray(item_t it);
    hit_t   res = '0;
    int     dx = int'($signed(it.direction_x));
    int     dy = int'($signed(it.direction_y));
    int     w = clamp_side(width_reg);
    int     h = clamp_side(height_reg);
    longint ax = (dx < 0) ? -dx : dx;
    longint ay = (dy < 0) ? -dy : dy;
    longint root, ux, uy, lx, ly, walk_len;
    int     cx, cy, sx, sy, addr;
    longint fx, fy;
    root = longint'(int_sqrt(64'((ax * ax + ay * ay) << 20)));
    ux = (ax == 0) ? longint'(StepSat) : sat_len(root / ax);
    uy = (ay == 0) ? longint'(StepSat) : sat_len(root / ay);
    cx = int'(it.origin_x >> 10);
    cy = int'(it.origin_y >> 10);
    fx = it.origin_x & 16'h3FF;
    fy = it.origin_y & 16'h3FF;
    sx = (dx < 0) ? -1 : 1;
    sy = (dy < 0) ? -1 : 1;
    lx = sat_len((((dx < 0) ? fx : 1024 - fx) * ux) >>> 10);
    ly = sat_len((((dy < 0) ? fy : 1024 - fy) * uy) >>> 10);
    forever begin
      if (lx < ly) begin
        cx += sx;
        walk_len = lx;
        lx = sat_len(lx + ux);
      end else begin
        cy += sy;
        walk_len = ly;
        ly = sat_len(ly + uy);
      end
      if (walk_len > range_reg) return res;
      if (cx < 0 || cy < 0 || cx >= w || cy >= h) return res;
      addr = cy * w + cx;
      if (addr >= MapCellsDef) return res;
      if (map_copy[addr] != EmptyCell) begin
        res.found = 1'b1;
        res.x = hit_coord(it.origin_x, dx, walk_len);
        res.y = hit_coord(it.origin_y, dy, walk_len);
        res.tex = map_copy[addr] - TextureBase;
        return res;
      end
    end
  endfunction

  // Sender: a new beat is chosen at the falling edge once the previous one has been taken.
  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (!rst) begin
      if (accept_seen != accept_count) begin
        accept_seen = accept_count;
        nv = 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!send_hold && pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_tvalid <= nv;
    s_tuser  <= cur_beat.command;
    s_tdata  <= {4'b0, cur_beat.direction_y, cur_beat.direction_x, cur_beat.origin_y,
                 cur_beat.origin_x, cur_beat.cell_value, cur_beat.cell_index};
  end

  // Receiver: random stalls, plus one long hold-off requested from the stimulus.
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_req) begin
      rdy = 1'b0;
      hold_count++;
      if (hold_count >= 600) begin
        hold_req = 1'b0;
        hold_count = 0;
      end
    end else if (recv_gap > 0) begin
      rdy = 1'b0;
      recv_gap--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 15);
    end
    m_tready <= rdy;
  end

  // Input side: each accepted beat updates the shadow map or queues the expected hit.
  always @(posedge clk) begin
    item_t it;
    if (!rst && s_tvalid && s_tready) begin
      it = cur_beat;
      accept_count++;
      if (it.command == CmdWrite) begin
        map_copy[it.cell_index] = it.cell_value;
      end else begin
        expected_hits.push_back(trace_ray(it));
      end
    end
  end

  // Output side: compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    hit_t want;
    if (!rst && m_tvalid && m_tready) begin
      casts_seen++;
      if (m_tuser) hits_seen++;
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat found=%0b data=%h", $realtime, m_tuser, m_tdata);
      end else begin
        want = expected_hits.pop_front();
        if (m_tuser !== want.found || m_tdata[15:0] !== want.x ||
            m_tdata[31:16] !== want.y || m_tdata[39:32] !== want.tex) begin
          errors++;
          $display("%0t: mismatch expected found=%0b x=%h y=%h tex=%h, got found=%0b x=%h y=%h tex=%h",
                   $realtime, want.found, want.x, want.y, want.tex,
                   m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32]);
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegWidth:   width_reg = val[6:0];
      RegHeight:  height_reg = val[6:0];
      RegMaxDist: range_reg = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until every beat is sent and every result is back, then lets the engine settle.
  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || expected_hits.size() > 0 || hold_req)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic item_t map_write(int idx, int val);
    item_t it = '0;
    it.command = CmdWrite;
    it.cell_index = idx[11:0];
    it.cell_value = val[7:0];
    return it;
  endfunction

  function automatic item_t ray(int ox, int oy, int dx, int dy);
    item_t it = '0;
    it.command = CmdCast;
    it.origin_x = ox[15:0];
    it.origin_y = oy[15:0];
    it.direction_x = dx[15:0];
    it.direction_y = dy[15:0];
    return it;
  endfunction

  // Random cast: mostly starts inside the map in use, some anywhere; a few axis-aligned.
  function automatic item_t random_ray();
    int span_x = clamp_side(width_reg) * 1024 - 1;
    int span_y = clamp_side(height_reg) * 1024 - 1;
    int ox = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span_x);
    int oy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span_y);
    int dx = $urandom_range(0, 65535);
    int dy = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0: dx = 0;
      1: dy = 0;
      2: dx = $urandom_range(0, 31) - 16;
      default: ;
    endcase
    return ray(ox, oy, dx, dy);
  endfunction

  function automatic item_t random_write();
    int val = ($urandom_range(0, 9) < 6) ? 32 : $urandom_range(0, 255);
    return map_write($urandom_range(0, 4095), val);
  endfunction

  task automatic random_phase(int n, int w, int h, int d);
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    reg_write(RegMaxDist, d);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_beats.push_back(random_write());
        writes_sent++;
      end else begin
        pending_beats.push_back(random_ray());
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every cell any map shape below can reach is written before any cast, so no unwritten
    // cell is ever read.
    for (int i = 0; i < FillCells; i++) begin
      pending_beats.push_back(map_write(i, ($urandom_range(0, 9) < 7) ? 32 : $urandom_range(0, 255)));
      writes_sent++;
    end
    drain();
    reg_write(RegWidth, 32);
    reg_write(RegHeight, 32);

    // Directed: border walls at the byte extremes, zero direction, axis rays, direction extremes.
    pending_beats.push_back(map_write(0, 0));
    pending_beats.push_back(map_write(4095, 255));
    pending_beats.push_back(map_write(63, 8'h30));
    writes_sent += 3;
    pending_beats.push_back(ray(2048, 2048, 0, 0));
    pending_beats.push_back(ray(512, 512, -16384, 0));
    pending_beats.push_back(ray(512, 512, 0, -16384));
    pending_beats.push_back(ray(0, 0, 16384, 0));
    pending_beats.push_back(ray(0, 0, 0, 16384));
    pending_beats.push_back(ray(65535, 65535, -32768, -32768));
    pending_beats.push_back(ray(65535, 65535, 32767, 32767));
    pending_beats.push_back(ray(0, 65535, 32767, -32768));
    pending_beats.push_back(ray(30000, 30000, 1, -1));
    pending_beats.push_back(ray(30000, 30000, 11585, 11585));
    pending_beats.push_back(ray(1023, 1023, -1, 1));
    pending_beats.push_back(ray(40000, 20000, -32768, 5));
    drain();
    reg_write(RegMaxDist, 0);
    pending_beats.push_back(ray(5000, 5000, 16384, 100));
    pending_beats.push_back(ray(5000, 5000, -100, -16384));
    drain();

    // Random phases at several map shapes and ranges, out-of-range register values included.
    random_phase(60, 32, 32, 61440);
    random_phase(40, 1, 1, 65535);
    random_phase(40, 0, 127, 0);
    random_phase(60, 17, 9, 3000);

    // The receiver holds off for a long stretch while the sender keeps offering casts.
    reg_write(RegWidth, 32);
    reg_write(RegHeight, 32);
    reg_write(RegMaxDist, 65535);
    hold_req = 1'b1;
    repeat (40) pending_beats.push_back(random_ray());
    drain();

    // The sender pauses until every outstanding result has come back.
    repeat (30) pending_beats.push_back(random_ray());
    repeat (150) @(posedge clk);
    send_hold = 1'b1;
    while (expected_hits.size() > 0 || s_tvalid) @(posedge clk);
    send_hold = 1'b0;
    drain();

    random_phase(40, 127, 0, 20000);
    random_phase(40, 8, 8, 61440);
    quiet = 1'b1;
    random_phase(60, 32, 32, 65535);

    $display("Run covered %0d map writes and %0d casts (%0d hits, %0d misses).",
             writes_sent, casts_seen, hits_seen, casts_seen - hits_seen);
    $display("Map shapes from 1x1 to 32x32 plus clamped 64-cell strips, ranges 0 to 65535.");
    if (errors == 0) begin
      $display("[grid_dda_ray_cast_top] OK");
    end else begin
      $display("[grid_dda_ray_cast_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[grid_dda_ray_cast_top] ERROR");
    $finish;
  end
endmodule

### files.f
src/gdr_pkg.sv
src/gdr_front.sv
src/gdr_back.sv
src/grid_dda_ray_cast_top.sv
src/gdr_checker.sv
test/tb.sv
